// ===== sv/rpc_pkg.sv =====
// shared types, constants and register codes for the rc pulse capture block
// no dependencies; used by rpc_eval, the top level and the checker by scoped names
package rpc_pkg;

   localparam int CHANNELS     = 6;
   localparam int TIME_BITS    = 48;
   localparam int CH_ADDR_W    = $clog2(CHANNELS);
   localparam int CH_BITS      = 3;
   localparam int OP_BITS      = 2;
   localparam int WIDTH_BITS   = 16;
   localparam int TIMEOUT_BITS = 24;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 24;

   localparam logic [CH_BITS:0] CH_COUNT = (CH_BITS + 1)'(CHANNELS);

   // item kinds
   localparam logic [OP_BITS-1:0] OP_EDGE = 2'd0;
   localparam logic [OP_BITS-1:0] OP_READ = 2'd1;
   localparam logic [OP_BITS-1:0] OP_POLL = 2'd2;
   localparam logic [OP_BITS-1:0] OP_NONE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOSS_TIMEOUT = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DISCRETE_THR = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NOISE_BAND   = 3'd4;

   // register reset values
   localparam logic [WIDTH_BITS-1:0]   RST_MIN_WIDTH    = 16'd800;
   localparam logic [WIDTH_BITS-1:0]   RST_MAX_WIDTH    = 16'd2200;
   localparam logic [TIMEOUT_BITS-1:0] RST_LOSS_TIMEOUT = 24'd100000;
   localparam logic [WIDTH_BITS-1:0]   RST_DISCRETE_THR = 16'd1500;
   localparam logic [WIDTH_BITS-1:0]   RST_NOISE_BAND   = 16'd10;

   // stream payload layout
   localparam int REQ_TDATA_BITS = 56;
   localparam int REQ_USED_BITS  = CH_BITS + 1 + TIME_BITS;
   localparam int RSP_TDATA_BITS = 24;
   localparam int RSP_USED_BITS  = 6 + WIDTH_BITS;

   localparam int RSP_ACCEPTED_BIT = 0;
   localparam int RSP_VALID_BIT    = 1 + WIDTH_BITS;
   localparam int RSP_DISCRETE_BIT = 2 + WIDTH_BITS;
   localparam int RSP_OK_BIT       = 3 + WIDTH_BITS;
   localparam int RSP_SEEN_BIT     = 4 + WIDTH_BITS;
   localparam int RSP_CHANGE_BIT   = 5 + WIDTH_BITS;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]   min_width;
      logic [WIDTH_BITS-1:0]   max_width;
      logic [TIMEOUT_BITS-1:0] loss_timeout;
      logic [WIDTH_BITS-1:0]   discrete_thr;
      logic [WIDTH_BITS-1:0]   noise_band;
   } cfg_type;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic [CH_BITS-1:0]   channel;
      logic                 level;
      logic [TIME_BITS-1:0] time_us;
   } item_type;

   // one channel's record in the state memory
   typedef struct packed {
      logic [TIME_BITS-1:0]  rise_time;
      logic                  rise_recorded;
      logic [WIDTH_BITS-1:0] width;
      logic                  width_valid;
      logic [TIME_BITS-1:0]  update_time;
      logic [WIDTH_BITS-1:0] reported_width;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic                  accepted;
      logic [WIDTH_BITS-1:0] pulse_width;
      logic                  pulse_valid;
      logic                  discrete_on;
      logic                  signal_ok;
      logic                  signal_seen;
      logic                  change_report;
   } result_type;

   // write-back and global update from the evaluate stage
   typedef struct packed {
      logic      entry_wr;
      entry_type entry;
      logic      accept;
   } update_type;

endpackage

// ===== sv/rpc_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module rpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rpc_eval.sv =====
// evaluate stage: measures widths, applies stale clear and change report
// depends on rpc_pkg
module rpc_eval (
   input  rpc_pkg::item_type                   item,
   input  rpc_pkg::entry_type                  entry,
   input  rpc_pkg::cfg_type                    cfg,
   input  logic [rpc_pkg::TIME_BITS-1:0]       last_accept,
   input  logic                                seen,
   output rpc_pkg::update_type                 upd,
   output rpc_pkg::result_type                 result
);

   logic                              in_range;
   logic                              is_edge;
   logic                              is_poll;
   logic [rpc_pkg::TIME_BITS-1:0]     pulse_w;
   logic [rpc_pkg::TIME_BITS-1:0]     age;
   logic [rpc_pkg::TIME_BITS-1:0]     sig_age;
   logic [rpc_pkg::TIME_BITS-1:0]     timeout_ext;
   logic [rpc_pkg::WIDTH_BITS-1:0]    diff;
   logic                              in_limits;
   logic                              fresh;
   logic                              accept;
   logic                              change;
   rpc_pkg::entry_type                nxt;

   always_comb begin
      in_range    = ({1'b0, item.channel} < rpc_pkg::CH_COUNT) && (item.op != rpc_pkg::OP_NONE);
      is_edge     = item.op == rpc_pkg::OP_EDGE;
      is_poll     = item.op == rpc_pkg::OP_POLL;
      timeout_ext = {{(rpc_pkg::TIME_BITS - rpc_pkg::TIMEOUT_BITS){1'b0}}, cfg.loss_timeout};
      pulse_w     = item.time_us - entry.rise_time;
      in_limits   = (pulse_w[rpc_pkg::TIME_BITS-1:rpc_pkg::WIDTH_BITS] == '0)
                    && (pulse_w[rpc_pkg::WIDTH_BITS-1:0] >= cfg.min_width)
                    && (pulse_w[rpc_pkg::WIDTH_BITS-1:0] <= cfg.max_width);
      age         = item.time_us - entry.update_time;
      fresh       = age < timeout_ext;
      accept      = in_range && is_edge && !item.level && entry.rise_recorded && in_limits;

      nxt = entry;
      if (is_edge && item.level) begin
         nxt.rise_time     = item.time_us;
         nxt.rise_recorded = 1'b1;
      end
      if (accept) begin
         nxt.width       = pulse_w[rpc_pkg::WIDTH_BITS-1:0];
         nxt.width_valid = 1'b1;
         nxt.update_time = item.time_us;
      end
      if (!is_edge && !fresh) begin
         nxt.width_valid = 1'b0;
      end

      // a poll never accepts, so the stored width is the one reported
      diff = (entry.width >= entry.reported_width) ? entry.width - entry.reported_width
                                                   : entry.reported_width - entry.width;
      change = is_poll && nxt.width_valid
               && ((entry.reported_width == '0) || (diff >= cfg.noise_band));
      if (change) begin
         nxt.reported_width = nxt.width;
      end

      // an accept restamps the signal, so its age is zero
      sig_age  = item.time_us - last_accept;

      upd.entry_wr = in_range;
      upd.entry    = nxt;
      upd.accept   = accept;

      result.accepted      = accept;
      result.pulse_width   = in_range ? nxt.width : '0;
      result.pulse_valid   = in_range && nxt.width_valid;
      result.discrete_on   = in_range && nxt.width_valid && (nxt.width > cfg.discrete_thr);
      result.signal_ok     = accept ? (cfg.loss_timeout != '0) : (sig_age < timeout_ext);
      result.signal_seen   = seen || accept;
      result.change_report = in_range && change;
   end

endmodule

// ===== sv/rc_pwm_pulse_capture.sv =====
// rc pulse capture top level: stream ports, config registers, state ram
// a request is registered in s1 and its result in the response register
// throughput: one item per cycle when not stalled; state is read on request transfer
// from a ram of one entry per channel, written back, forwarded on back-to-back hits
// reset clears registers to defaults, channel valid bits, signal state and pipeline
module rc_pwm_pulse_capture (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // channel, level, time_us, zero pad
   input  logic [rpc_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   // op
   input  logic [rpc_pkg::OP_BITS-1:0]           req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // accepted, pulse_width, pulse_valid, discrete_on, signal_ok, signal_seen,
   // change_report, zero pad
   output logic [rpc_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rpc_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [rpc_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   rpc_pkg::cfg_type                     cfg_ff;
   logic                                 s1_valid_ff;
   rpc_pkg::item_type                    s1_item_ff;
   logic                                 rd_live_ff;
   logic                                 byp_ff;
   rpc_pkg::entry_type                   byp_data_ff;
   logic [rpc_pkg::CHANNELS-1:0]         entry_valid_ff;
   logic [rpc_pkg::TIME_BITS-1:0]        last_accept_ff;
   logic                                 seen_ff;
   logic                                 rsp_valid_ff;
   logic [rpc_pkg::RSP_TDATA_BITS-1:0]   rsp_data_ff;

   rpc_pkg::item_type                    req_item;
   logic                                 req_fire;
   logic                                 req_in_range;
   logic                                 s1_advance;
   logic                                 wr_fire;
   logic [rpc_pkg::CH_ADDR_W-1:0]        rd_addr;
   logic [rpc_pkg::CH_ADDR_W-1:0]        wr_addr;
   logic                                 byp_in;
   logic [rpc_pkg::ENTRY_BITS-1:0]       ram_rdata;
   rpc_pkg::entry_type                   entry_now;
   rpc_pkg::update_type                  upd;
   rpc_pkg::result_type                  result;
   logic [rpc_pkg::RSP_TDATA_BITS-1:0]   rsp_data_in;

   assign req_item.op      = req_tuser;
   assign req_item.channel = req_tdata[rpc_pkg::CH_BITS-1:0];
   assign req_item.level   = req_tdata[rpc_pkg::CH_BITS];
   assign req_item.time_us = req_tdata[rpc_pkg::REQ_USED_BITS-1:rpc_pkg::CH_BITS+1];

   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !s1_valid_ff || s1_advance;
   assign req_fire     = req_tvalid && req_tready;
   assign req_in_range = {1'b0, req_item.channel} < rpc_pkg::CH_COUNT;
   assign rd_addr      = req_item.channel[rpc_pkg::CH_ADDR_W-1:0];
   assign wr_addr      = s1_item_ff.channel[rpc_pkg::CH_ADDR_W-1:0];
   assign wr_fire      = s1_advance && upd.entry_wr;
   assign byp_in       = wr_fire && (wr_addr == rd_addr);
   assign csr_ready    = 1'b1;

   rpc_ram #(
      .WIDTH (rpc_pkg::ENTRY_BITS),
      .DEPTH (rpc_pkg::CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_fire),
      .wr_addr (wr_addr),
      .wr_data (upd.entry),
      .rd_en   (req_fire && req_in_range),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // forwarded write-back wins over the ram, never-written entries read as zero
   always_comb begin
      if (byp_ff) begin
         entry_now = byp_data_ff;
      end else if (rd_live_ff) begin
         entry_now = rpc_pkg::entry_type'(ram_rdata);
      end else begin
         entry_now = '0;
      end
   end

   rpc_eval u_eval (
      .item        (s1_item_ff),
      .entry       (entry_now),
      .cfg         (cfg_ff),
      .last_accept (last_accept_ff),
      .seen        (seen_ff),
      .upd         (upd),
      .result      (result)
   );

   assign rsp_data_in = {{(rpc_pkg::RSP_TDATA_BITS - rpc_pkg::RSP_USED_BITS){1'b0}},
                         result.change_report, result.signal_seen, result.signal_ok,
                         result.discrete_on, result.pulse_valid, result.pulse_width,
                         result.accepted};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_width    <= rpc_pkg::RST_MIN_WIDTH;
         cfg_ff.max_width    <= rpc_pkg::RST_MAX_WIDTH;
         cfg_ff.loss_timeout <= rpc_pkg::RST_LOSS_TIMEOUT;
         cfg_ff.discrete_thr <= rpc_pkg::RST_DISCRETE_THR;
         cfg_ff.noise_band   <= rpc_pkg::RST_NOISE_BAND;
      end else if (csr_valid) begin
         case (csr_index)
            rpc_pkg::CSR_MIN_WIDTH: begin
               cfg_ff.min_width <= csr_wdata[rpc_pkg::WIDTH_BITS-1:0];
            end
            rpc_pkg::CSR_MAX_WIDTH: begin
               cfg_ff.max_width <= csr_wdata[rpc_pkg::WIDTH_BITS-1:0];
            end
            rpc_pkg::CSR_LOSS_TIMEOUT: begin
               cfg_ff.loss_timeout <= csr_wdata[rpc_pkg::TIMEOUT_BITS-1:0];
            end
            rpc_pkg::CSR_DISCRETE_THR: begin
               cfg_ff.discrete_thr <= csr_wdata[rpc_pkg::WIDTH_BITS-1:0];
            end
            rpc_pkg::CSR_NOISE_BAND: begin
               cfg_ff.noise_band <= csr_wdata[rpc_pkg::WIDTH_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         last_accept_ff <= '0;
         seen_ff        <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_fire) begin
            entry_valid_ff[wr_addr] <= 1'b1;
         end
         if (s1_advance && upd.accept) begin
            last_accept_ff <= s1_item_ff.time_us;
            seen_ff        <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff  <= req_item;
         byp_ff      <= byp_in;
         byp_data_ff <= upd.entry;
         rd_live_ff  <= req_in_range && entry_valid_ff[rd_addr];
      end
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sv/rpc_checker.sv =====
// port-level checks for the rc pulse capture top level, bound to every instance
// depends on rpc_pkg and rc_pwm_pulse_capture
module rpc_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [rpc_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // a request transfer while the output is ready is followed by an offered result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tready |=> ##1 rsp_tvalid)
      else $error("result missing after request transfer");

   a_discrete: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[rpc_pkg::RSP_DISCRETE_BIT] |-> rsp_tdata[rpc_pkg::RSP_VALID_BIT])
      else $error("discrete_on without pulse_valid");

   a_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[rpc_pkg::RSP_ACCEPTED_BIT]
      |-> rsp_tdata[rpc_pkg::RSP_VALID_BIT] && rsp_tdata[rpc_pkg::RSP_SEEN_BIT])
      else $error("accepted width not marked valid and seen");

   a_change: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[rpc_pkg::RSP_CHANGE_BIT] |-> rsp_tdata[rpc_pkg::RSP_VALID_BIT]
      && !rsp_tdata[rpc_pkg::RSP_ACCEPTED_BIT])
      else $error("change report without valid poll");

endmodule

bind rc_pwm_pulse_capture rpc_checker u_rpc_checker (.*);
